FILE: hdl/vct_pkg.sv
package vct_pkg;

    localparam int COORD_FRAC_BITS = 8;
    localparam int SCALE_FRAC_BITS = 16;
    localparam int ROT_FRAC_BITS   = 16;

    localparam int COORD_W    = 32;
    localparam int SCALE_W    = 24;
    localparam int TRIG_W     = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // intermediate values live in +-(2^44 - 1)
    localparam int INT_W  = 45;
    localparam int MB_W   = SCALE_W + 1;
    localparam int PROD_W = INT_W + MB_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int NUM_W  = INT_W + SCALE_FRAC_BITS;
    localparam int DCNT_W = $clog2(NUM_W + 1);

    localparam logic [INT_W-1:0] INTER_LIMIT = {1'b0, {(INT_W-1){1'b1}}};

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_FWD_POINT  = 2'd0,
        CMD_INV_POINT  = 2'd1,
        CMD_FWD_BOUNDS = 2'd2,
        CMD_INV_BOUNDS = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        RND_KEEP  = 2'd0,
        RND_TRUNC = 2'd1,
        RND_HALF  = 2'd2
    } t_round;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE_H = 3'd0,
        CFG_SCALE_V = 3'd1,
        CFG_VOFF_H  = 3'd2,
        CFG_VOFF_V  = 3'd3,
        CFG_COS     = 3'd4,
        CFG_SIN     = 3'd5,
        CFG_RSH_H   = 3'd6,
        CFG_RSH_V   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic        [SCALE_W-1:0] scale_h;
        logic        [SCALE_W-1:0] scale_v;
        logic signed [COORD_W-1:0] voff_h;
        logic signed [COORD_W-1:0] voff_v;
        logic signed [TRIG_W-1:0]  cosine;
        logic signed [TRIG_W-1:0]  sine;
        logic signed [COORD_W-1:0] rsh_h;
        logic signed [COORD_W-1:0] rsh_v;
        logic                      rot_on;
    } t_cfg;

    typedef struct packed {
        logic                      inv;
        logic                      bounds;
        logic                      trunc;
        logic                      half;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic signed [COORD_W-1:0] x2;
        logic signed [COORD_W-1:0] y2;
    } t_item;

endpackage

FILE: hdl/vct_front.sv
module vct_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [1:0]                         i_command,
    input  logic signed [vct_pkg::COORD_W-1:0] i_in_x,
    input  logic signed [vct_pkg::COORD_W-1:0] i_in_y,
    input  logic signed [vct_pkg::COORD_W-1:0] i_in_x2,
    input  logic signed [vct_pkg::COORD_W-1:0] i_in_y2,
    input  logic [1:0]                         i_round_mode,
    output vct_pkg::t_item                     o_item,
    output logic                               o_item_valid,
    input  logic                               i_item_pop
);

    vct_pkg::t_item                   r_q [vct_pkg::QUEUE_DEPTH];
    logic [vct_pkg::QPTR_W-1:0]       r_wr, r_rd;
    logic [vct_pkg::QCNT_W-1:0]       r_cnt;
    vct_pkg::t_item                   cls;
    logic                             push, pop;

    // decode command and round mode into flags
    always_comb begin
        cls       = '0;
        cls.x1    = i_in_x;
        cls.y1    = i_in_y;
        cls.x2    = i_in_x2;
        cls.y2    = i_in_y2;
        case (vct_pkg::t_cmd'(i_command))
            vct_pkg::CMD_FWD_POINT:  begin cls.inv = 1'b0; cls.bounds = 1'b0; end
            vct_pkg::CMD_INV_POINT:  begin cls.inv = 1'b1; cls.bounds = 1'b0; end
            vct_pkg::CMD_FWD_BOUNDS: begin cls.inv = 1'b0; cls.bounds = 1'b1; end
            default:                 begin cls.inv = 1'b1; cls.bounds = 1'b1; end
        endcase
        case (vct_pkg::t_round'(i_round_mode))
            vct_pkg::RND_TRUNC: begin cls.trunc = 1'b1; cls.half = 1'b0; end
            vct_pkg::RND_HALF:  begin cls.trunc = 1'b1; cls.half = 1'b1; end
            default:            begin cls.trunc = 1'b0; cls.half = 1'b0; end
        endcase
    end

    assign o_ready      = (r_cnt != vct_pkg::QCNT_W'(vct_pkg::QUEUE_DEPTH));
    assign push         = i_valid && o_ready;
    assign o_item_valid = (r_cnt != '0);
    assign pop          = i_item_pop && o_item_valid;
    assign o_item       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: hdl/vct_div.sv
module vct_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [vct_pkg::NUM_W-1:0]        i_num,
    input  logic [vct_pkg::SCALE_W-1:0]      i_den,
    output logic                             o_done,
    output logic [vct_pkg::NUM_W-1:0]        o_quo
);

    logic [vct_pkg::SCALE_W-1:0] r_rem, r_den;
    logic [vct_pkg::NUM_W-1:0]   r_quo;
    logic [vct_pkg::DCNT_W-1:0]  r_cnt;
    logic                        r_busy, r_done;
    logic [vct_pkg::SCALE_W:0]   trial, diff;
    logic                        qbit;

    // restoring division, one quotient bit per cycle
    assign trial = {r_rem, r_quo[vct_pkg::NUM_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign qbit  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[vct_pkg::NUM_W-2:0], qbit};
            r_rem <= qbit ? diff[vct_pkg::SCALE_W-1:0] : trial[vct_pkg::SCALE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == vct_pkg::DCNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= vct_pkg::DCNT_W'(vct_pkg::NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == vct_pkg::DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

FILE: hdl/vct_back.sv
module vct_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  vct_pkg::t_cfg                      i_cfg,
    input  vct_pkg::t_item                     i_item,
    input  logic                               i_item_valid,
    output logic                               o_item_pop,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [vct_pkg::COORD_W-1:0] o_out_x,
    output logic signed [vct_pkg::COORD_W-1:0] o_out_y,
    output logic signed [vct_pkg::COORD_W-1:0] o_out_x2,
    output logic signed [vct_pkg::COORD_W-1:0] o_out_y2,
    output logic                               o_saturated
);

    localparam int IW = vct_pkg::INT_W;
    localparam int CW = vct_pkg::COORD_W;
    localparam logic signed [IW:0] MAX32 = (IW+1)'(64'sd2147483647);
    localparam logic signed [IW:0] MIN32 = -(IW+1)'(64'sd2147483648);
    localparam logic [IW-1:0] FRAC_MASK = IW'((64'd1 << vct_pkg::COORD_FRAC_BITS) - 1);
    localparam logic [IW-1:0] HALF_ONE  = IW'(64'd1 << (vct_pkg::COORD_FRAC_BITS - 1));

    typedef enum logic [13:0] {
        ST_IDLE   = 14'b00000000000001,
        ST_LOAD   = 14'b00000000000010,
        ST_SCALE  = 14'b00000000000100,
        ST_OFFS   = 14'b00000000001000,
        ST_ROT1   = 14'b00000000010000,
        ST_ROT2   = 14'b00000000100000,
        ST_ROT3   = 14'b00000001000000,
        ST_IROT1  = 14'b00000010000000,
        ST_IROT2  = 14'b00000100000000,
        ST_IROT3  = 14'b00001000000000,
        ST_IOFFS  = 14'b00010000000000,
        ST_DIVX   = 14'b00100000000000,
        ST_DIVY   = 14'b01000000000000,
        ST_FIN    = 14'b10000000000000
    } t_state;

    t_state                           r_state, n_state;
    vct_pkg::t_item                   r_item;
    logic [1:0]                       r_corner;
    logic signed [IW-1:0]             r_a, r_b, n_a, n_b;
    logic signed [vct_pkg::PROD_W-1:0] r_p0, r_p1, m0, m1;
    logic signed [vct_pkg::ACC_W-1:0] r_acc;
    logic signed [IW-1:0]             r_lx, r_ly, r_hx, r_hy;
    logic                             r_sat, r_div_run;
    logic signed [IW-1:0]             m0_a, m1_a;
    logic signed [vct_pkg::MB_W-1:0]  m0_b, m1_b;
    logic signed [vct_pkg::MB_W-1:0]  sh_b, sv_b, cos_b, sin_b;
    logic signed [IW-1:0]             off_h, off_v, rsh_h, rsh_v, cx, cy;
    logic signed [vct_pkg::ACC_W-1:0] sum_p, dif_p;
    logic                             div_start, div_done, div_y, div_neg, div_clamp;
    logic [vct_pkg::NUM_W-1:0]        div_num, div_quo;
    logic [vct_pkg::SCALE_W-1:0]      div_den, div_scale;
    logic [IW-1:0]                    div_abs, div_mag;
    logic signed [IW-1:0]             div_res;
    logic                             last_corner, fin_fire;
    logic [CW:0]                      f_lx, f_ly, f_hx, f_hy;
    logic                             r_ovalid;

    // when trunc is set, trim to whole pixels, then clamp to 32 bits; top bit flags a clamp
    function automatic logic [CW:0] finish(input logic signed [IW-1:0] v,
                                           input logic trunc, input logic half);
        logic              neg;
        logic [IW-1:0]     m;
        logic signed [IW:0] r;
        begin
            neg = v[IW-1];
            m   = neg ? IW'(-v) : IW'(v);
            if (half) begin
                m = m + HALF_ONE;
            end
            m = m & ~FRAC_MASK;
            if (trunc) begin
                r = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
            end else begin
                r = (IW+1)'(v);
            end
            if (r > MAX32) begin
                finish = {1'b1, 1'b0, {(CW-1){1'b1}}};
            end else if (r < MIN32) begin
                finish = {1'b1, 1'b1, {(CW-1){1'b0}}};
            end else begin
                finish = {1'b0, r[CW-1:0]};
            end
        end
    endfunction

    assign sh_b  = $signed({1'b0, i_cfg.scale_h});
    assign sv_b  = $signed({1'b0, i_cfg.scale_v});
    assign cos_b = vct_pkg::MB_W'(i_cfg.cosine);
    assign sin_b = vct_pkg::MB_W'(i_cfg.sine);
    assign off_h = IW'(i_cfg.voff_h) <<< vct_pkg::COORD_FRAC_BITS;
    assign off_v = IW'(i_cfg.voff_v) <<< vct_pkg::COORD_FRAC_BITS;
    assign rsh_h = IW'(i_cfg.rsh_h);
    assign rsh_v = IW'(i_cfg.rsh_v);

    // corner order: (x1,y1) (x1,y2) (x2,y1) (x2,y2)
    assign cx = r_corner[1] ? IW'(r_item.x2) : IW'(r_item.x1);
    assign cy = r_corner[0] ? IW'(r_item.y2) : IW'(r_item.y1);
    assign last_corner = !r_item.bounds || (r_corner == 2'd3);

    // operand select for the two multipliers
    always_comb begin
        m0_a = r_a;
        m1_a = r_b;
        m0_b = cos_b;
        m1_b = sin_b;
        case (r_state)
            ST_SCALE: begin m0_b = sh_b;  m1_b = sv_b;  end
            ST_ROT2:  begin m0_b = sin_b; m1_b = cos_b; end
            ST_IROT2: begin m0_a = r_b;   m1_a = r_a;   end
            default:  begin m0_b = cos_b; m1_b = sin_b; end
        endcase
    end

    assign m0    = m0_a * m0_b;
    assign m1    = m1_a * m1_b;
    assign sum_p = vct_pkg::ACC_W'(r_p0) + vct_pkg::ACC_W'(r_p1);
    assign dif_p = vct_pkg::ACC_W'(r_p0) - vct_pkg::ACC_W'(r_p1);

    // divider feed: |v| << SCALE_FRAC_BITS over the scale (zero reads as one)
    assign div_y     = (r_state == ST_DIVY);
    assign div_neg   = div_y ? r_b[IW-1] : r_a[IW-1];
    assign div_abs   = div_y ? (r_b[IW-1] ? IW'(-r_b) : IW'(r_b))
                             : (r_a[IW-1] ? IW'(-r_a) : IW'(r_a));
    assign div_scale = div_y ? i_cfg.scale_v : i_cfg.scale_h;
    assign div_den   = (div_scale == '0) ? vct_pkg::SCALE_W'(1) : div_scale;
    assign div_num   = {div_abs, {vct_pkg::SCALE_FRAC_BITS{1'b0}}};
    assign div_start = (r_state == ST_DIVX || r_state == ST_DIVY) && !r_div_run;
    assign div_clamp = (div_quo > vct_pkg::NUM_W'(vct_pkg::INTER_LIMIT));
    assign div_mag   = div_clamp ? vct_pkg::INTER_LIMIT : div_quo[IW-1:0];
    assign div_res   = div_neg ? -$signed(div_mag) : $signed(div_mag);

    vct_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign f_lx = finish(r_lx, r_item.trunc, r_item.half);
    assign f_ly = finish(r_ly, r_item.trunc, r_item.half);
    assign f_hx = finish(r_hx, r_item.trunc, r_item.half);
    assign f_hy = finish(r_hy, r_item.trunc, r_item.half);

    assign fin_fire   = (r_state == ST_FIN) && (!r_ovalid || i_ready);
    assign o_item_pop = (r_state == ST_IDLE) && i_item_valid;

    // sequencer and working registers
    always_comb begin
        n_state = r_state;
        n_a     = r_a;
        n_b     = r_b;
        case (r_state)
            ST_IDLE: begin
                if (i_item_valid) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (!r_item.inv) begin
                    n_a     = cx;
                    n_b     = cy;
                    n_state = ST_SCALE;
                end else if (i_cfg.rot_on) begin
                    n_a     = cx - rsh_h;
                    n_b     = cy - rsh_v;
                    n_state = ST_IROT1;
                end else begin
                    n_a     = cx;
                    n_b     = cy;
                    n_state = ST_IOFFS;
                end
            end
            ST_SCALE: n_state = ST_OFFS;
            ST_OFFS: begin
                n_a     = IW'(r_p0 >>> vct_pkg::SCALE_FRAC_BITS) - off_h;
                n_b     = IW'(r_p1 >>> vct_pkg::SCALE_FRAC_BITS) - off_v;
                n_state = i_cfg.rot_on ? ST_ROT1 : ST_FIN;
            end
            ST_ROT1: n_state = ST_ROT2;
            ST_ROT2: n_state = ST_ROT3;
            ST_ROT3: begin
                n_a     = IW'(r_acc >>> vct_pkg::ROT_FRAC_BITS) + rsh_h;
                n_b     = IW'(sum_p >>> vct_pkg::ROT_FRAC_BITS) + rsh_v;
                n_state = ST_FIN;
            end
            ST_IROT1: n_state = ST_IROT2;
            ST_IROT2: n_state = ST_IROT3;
            ST_IROT3: begin
                n_a     = IW'(r_acc >>> vct_pkg::ROT_FRAC_BITS);
                n_b     = IW'(dif_p >>> vct_pkg::ROT_FRAC_BITS);
                n_state = ST_IOFFS;
            end
            ST_IOFFS: begin
                n_a     = r_a + off_h;
                n_b     = r_b + off_v;
                n_state = ST_DIVX;
            end
            ST_DIVX: begin
                if (div_done) begin
                    n_a     = div_res;
                    n_state = ST_DIVY;
                end
            end
            ST_DIVY: begin
                if (div_done) begin
                    n_b     = div_res;
                    n_state = ST_FIN;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_a  <= n_a;
        r_b  <= n_b;
        r_p0 <= m0;
        r_p1 <= m1;
        if (r_state == ST_ROT2) begin
            r_acc <= dif_p;
        end else if (r_state == ST_IROT2) begin
            r_acc <= sum_p;
        end
        if (o_item_pop) begin
            r_item <= i_item;
        end
        if (fin_fire) begin
            o_out_x     <= f_lx[CW-1:0];
            o_out_y     <= f_ly[CW-1:0];
            o_out_x2    <= r_item.bounds ? f_hx[CW-1:0] : '0;
            o_out_y2    <= r_item.bounds ? f_hy[CW-1:0] : '0;
            o_saturated <= r_sat || f_lx[CW] || f_ly[CW] ||
                           (r_item.bounds && (f_hx[CW] || f_hy[CW]));
        end
    end

    // corner results land here: update bounds when entering ST_FIN
    logic corner_end;
    logic signed [IW-1:0] nx, ny;
    assign corner_end = (n_state == ST_FIN) && (r_state != ST_FIN);
    assign nx = n_a;
    assign ny = n_b;

    always_ff @(posedge i_clk) begin
        if (corner_end) begin
            if (r_corner == 2'd0 || nx < r_lx) r_lx <= nx;
            if (r_corner == 2'd0 || nx > r_hx) r_hx <= nx;
            if (r_corner == 2'd0 || ny < r_ly) r_ly <= ny;
            if (r_corner == 2'd0 || ny > r_hy) r_hy <= ny;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_corner  <= '0;
            r_sat     <= 1'b0;
            r_div_run <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            if (div_start) begin
                r_div_run <= 1'b1;
            end else if (div_done) begin
                r_div_run <= 1'b0;
            end
            if (r_state == ST_IDLE) begin
                r_sat    <= 1'b0;
                r_corner <= '0;
            end else if (div_done && div_clamp) begin
                r_sat <= 1'b1;
            end
            if (r_state == ST_FIN) begin
                if (!last_corner) begin
                    // advance to the next corner
                    r_corner <= r_corner + 1'b1;
                    r_state  <= ST_LOAD;
                end else if (fin_fire) begin
                    r_state <= ST_IDLE;
                end
            end else begin
                r_state <= n_state;
            end
            if (fin_fire && last_corner) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid = r_ovalid;

endmodule

FILE: hdl/viewport_coordinate_transform.sv
// Throughput: the back end takes one item at a time and pops the next from the queue
//   only when idle; bounds run four corners, and the 61-step restoring divider runs
//   twice per inverse corner.
// Reset: synchronous active-low i_rst_n empties the queue, idles the sequencer,
//   drops any pending result and loads the register defaults.
module viewport_coordinate_transform (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [vct_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [vct_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    // item input
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [1:0]                            i_command,
    input  logic signed [vct_pkg::COORD_W-1:0]    i_in_x,
    input  logic signed [vct_pkg::COORD_W-1:0]    i_in_y,
    input  logic signed [vct_pkg::COORD_W-1:0]    i_in_x2,
    input  logic signed [vct_pkg::COORD_W-1:0]    i_in_y2,
    input  logic [1:0]                            i_round_mode,
    // result output
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [vct_pkg::COORD_W-1:0]    o_out_x,
    output logic signed [vct_pkg::COORD_W-1:0]    o_out_y,
    output logic signed [vct_pkg::COORD_W-1:0]    o_out_x2,
    output logic signed [vct_pkg::COORD_W-1:0]    o_out_y2,
    output logic                                  o_saturated
);

    vct_pkg::t_cfg  r_cfg, cfg;
    vct_pkg::t_item q_item;
    logic           q_valid, q_pop;

    // registers always take a write
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale_h <= vct_pkg::SCALE_W'(65536);
            r_cfg.scale_v <= vct_pkg::SCALE_W'(65536);
            r_cfg.voff_h  <= '0;
            r_cfg.voff_v  <= '0;
            r_cfg.cosine  <= vct_pkg::TRIG_W'(65536);
            r_cfg.sine    <= '0;
            r_cfg.rsh_h   <= '0;
            r_cfg.rsh_v   <= '0;
            r_cfg.rot_on  <= 1'b0;
        end else if (i_cfg_valid) begin
            case (vct_pkg::t_cfg_idx'(i_cfg_index))
                vct_pkg::CFG_SCALE_H: r_cfg.scale_h <= i_cfg_data[vct_pkg::SCALE_W-1:0];
                vct_pkg::CFG_SCALE_V: r_cfg.scale_v <= i_cfg_data[vct_pkg::SCALE_W-1:0];
                vct_pkg::CFG_VOFF_H:  r_cfg.voff_h  <= i_cfg_data;
                vct_pkg::CFG_VOFF_V:  r_cfg.voff_v  <= i_cfg_data;
                vct_pkg::CFG_COS:     r_cfg.cosine  <= i_cfg_data[vct_pkg::TRIG_W-1:0];
                vct_pkg::CFG_SIN:     r_cfg.sine    <= i_cfg_data[vct_pkg::TRIG_W-1:0];
                vct_pkg::CFG_RSH_H:   r_cfg.rsh_h   <= i_cfg_data;
                default:              r_cfg.rsh_v   <= i_cfg_data;
            endcase
        end
    end

    // rotation runs unless cosine, sine and both shifts are all zero
    always_comb begin
        cfg        = r_cfg;
        cfg.rot_on = (r_cfg.cosine != '0) || (r_cfg.sine != '0) ||
                     (r_cfg.rsh_h != '0) || (r_cfg.rsh_v != '0);
    end

    // front: classify and queue items
    vct_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_command    (i_command),
        .i_in_x       (i_in_x),
        .i_in_y       (i_in_y),
        .i_in_x2      (i_in_x2),
        .i_in_y2      (i_in_y2),
        .i_round_mode (i_round_mode),
        .o_item       (q_item),
        .o_item_valid (q_valid),
        .i_item_pop   (q_pop)
    );

    // back: transform corners, reduce to bounds, round and clamp
    vct_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_item       (q_item),
        .i_item_valid (q_valid),
        .o_item_pop   (q_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_out_x2     (o_out_x2),
        .o_out_y2     (o_out_y2),
        .o_saturated  (o_saturated)
    );

endmodule
